// File: src/rim_pkg.sv
// Shared types and constants for the rectangle IoU best-match unit.
// Depends on nothing; every other file in src imports it.
package rim_pkg;

	localparam int COORD_BITS     = 16;
	localparam int MAX_CANDIDATES = 1024;

	localparam int THR_W     = 17;
	localparam int THR_RESET = 32768;
	localparam int ONE_Q16   = 65536;

	localparam int AREA_W = 2 * COORD_BITS;
	localparam int UNI_W  = AREA_W + 1;
	localparam int NUM_W  = (AREA_W > THR_W) ? AREA_W : THR_W;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);

	localparam int DIG_W  = 16;
	localparam int DIG_N  = (UNI_W + DIG_W - 1) / DIG_W;
	localparam int PAD_W  = DIG_N * DIG_W;
	localparam int DCNT_W = $clog2(DIG_N);
	localparam int PROD_W = NUM_W + UNI_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CAND = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_CAND,
		KIND_SKIP
	} rim_kind_t;

	typedef struct packed {
		rim_kind_t              kind;
		logic                   last;
		logic [COORD_BITS-1:0]  rect_w;
		logic [COORD_BITS-1:0]  rect_h;
		logic [COORD_BITS-1:0]  inter_w;
		logic [COORD_BITS-1:0]  inter_h;
		logic [CNT_W-1:0]       index;
	} rim_entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AREA,
		B_UNION,
		B_MUL,
		B_CMP,
		B_EMIT
	} rim_bstate_t;

endpackage

// File: src/rim_front.sv
// Front end: accepts input beats, tracks the test rectangle and candidate count,
// classifies each beat and computes the overlap spans. Uses rim_pkg.
module rim_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_x,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_y,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_w,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_h,
	input  logic                           last,
	input  logic                           q_full,
	output logic                           q_push,
	output rim_pkg::rim_entry_t            q_entry
);
	import rim_pkg::*;

	logic [COORD_BITS-1:0] test_x_q, test_y_q, test_w_q, test_h_q;
	logic [CNT_W-1:0]      count_q;
	logic                  accept;

	function automatic logic [COORD_BITS-1:0] span_overlap(
		input logic [COORD_BITS-1:0] p1, input logic [COORD_BITS-1:0] s1,
		input logic [COORD_BITS-1:0] p2, input logic [COORD_BITS-1:0] s2);
		logic [COORD_BITS:0] e1, e2, lo, hi, diff;
		e1 = {1'b0, p1} + {1'b0, s1};
		e2 = {1'b0, p2} + {1'b0, s2};
		lo = (p1 > p2) ? {1'b0, p1} : {1'b0, p2};
		hi = (e1 < e2) ? e1 : e2;
		diff = hi - lo;
		return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		q_entry.last    = last;
		q_entry.rect_w  = rect_w;
		q_entry.rect_h  = rect_h;
		q_entry.inter_w = span_overlap(test_x_q, test_w_q, rect_x, rect_w);
		q_entry.inter_h = span_overlap(test_y_q, test_h_q, rect_y, rect_h);
		q_entry.index   = count_q;
		if (op == OP_LOAD) begin
			q_entry.kind = KIND_LOAD;
		end else if (count_q == CNT_W'(MAX_CANDIDATES)) begin
			q_entry.kind = KIND_SKIP;
		end else begin
			q_entry.kind = KIND_CAND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_x_q <= '0;
			test_y_q <= '0;
			test_w_q <= '0;
			test_h_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			if (op == OP_LOAD) begin
				test_x_q <= rect_x;
				test_y_q <= rect_y;
				test_w_q <= rect_w;
				test_h_q <= rect_h;
				count_q  <= '0;
			end else if (count_q != CNT_W'(MAX_CANDIDATES)) begin
				count_q <= count_q + 1'b1;
			end
			if (last) begin
				count_q <= '0;
			end
		end
	end

endmodule

// File: src/rim_queue.sv
// Short FIFO of classified beats between the front end and the scoring back end.
// Uses rim_pkg for the entry type and depth.
module rim_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rim_pkg::rim_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output rim_pkg::rim_entry_t head
);
	import rim_pkg::*;

	rim_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/rim_back.sv
// Back end: computes areas, scores each candidate against the running best by
// digit-serial cross-multiplication, and holds the result register. Uses rim_pkg.
module rim_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  rim_pkg::rim_entry_t         q_head,
	output logic                        q_pop,
	input  logic [rim_pkg::THR_W-1:0]   threshold,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [rim_pkg::IDX_W-1:0]   best_index,
	output logic [rim_pkg::AREA_W-1:0]  best_intersection,
	output logic [rim_pkg::UNI_W-1:0]   best_union,
	output logic                        overflowed
);
	import rim_pkg::*;

	typedef struct packed {
		logic pop;
		logic start;
		logic skip;
		logic emit;
		logic win;
	} rim_bctl_t;

	rim_bstate_t           st_q, st_d;
	rim_bctl_t             ctl;
	rim_entry_t            ent_q;
	logic [COORD_BITS-1:0] tw_q, th_q;
	logic [AREA_W-1:0]     inter_q, ta_q, ca_q;
	logic [UNI_W-1:0]      uni_q, uni_d;
	logic [PAD_W-1:0]      den_sh_q, uni_sh_q;
	logic [DIG_W-1:0]      dig_den, dig_uni;
	logic [AREA_W+DIG_W-1:0] part_l;
	logic [NUM_W+DIG_W-1:0]  part_r;
	logic [PROD_W-1:0]     acc_l_q, acc_r_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  have_match_q, overflow_q, out_valid_q;
	logic [CNT_W-1:0]      best_pos_q;
	logic [NUM_W-1:0]      best_num_q;
	logic [UNI_W-1:0]      best_den_q;

	assign uni_d   = {1'b0, ta_q} + {1'b0, ca_q} - {1'b0, inter_q};
	assign dig_den = den_sh_q[PAD_W-1 -: DIG_W];
	assign dig_uni = uni_sh_q[PAD_W-1 -: DIG_W];
	assign part_l  = (AREA_W+DIG_W)'(inter_q) * (AREA_W+DIG_W)'(dig_den);
	assign part_r  = (NUM_W+DIG_W)'(best_num_q) * (NUM_W+DIG_W)'(dig_uni);
	assign q_pop   = ctl.pop;
	assign out_valid = out_valid_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_head.kind == KIND_CAND) begin
						st_d = B_AREA;
					end else if (q_head.last) begin
						st_d = B_EMIT;
					end
				end
			end
			B_AREA:  st_d = B_UNION;
			B_UNION: st_d = B_MUL;
			B_MUL: begin
				if (dcnt_q == DCNT_W'(DIG_N - 1)) begin
					st_d = B_CMP;
				end
			end
			B_CMP:   st_d = ent_q.last ? B_EMIT : B_IDLE;
			B_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (st_q)
			B_IDLE: begin
				ctl.pop   = !q_empty;
				ctl.start = !q_empty && (q_head.kind == KIND_LOAD);
				ctl.skip  = !q_empty && (q_head.kind == KIND_SKIP);
			end
			B_CMP: begin
				ctl.win = (uni_q != '0) && (acc_l_q > acc_r_q);
			end
			B_EMIT: begin
				ctl.emit  = !out_valid_q || !out_stall;
				ctl.start = !out_valid_q || !out_stall;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_IDLE;
			dcnt_q       <= '0;
			tw_q         <= '0;
			th_q         <= '0;
			have_match_q <= 1'b0;
			overflow_q   <= 1'b0;
			best_pos_q   <= '0;
			best_num_q   <= NUM_W'(THR_RESET);
			best_den_q   <= UNI_W'(ONE_Q16);
			out_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == B_MUL) begin
				dcnt_q <= dcnt_q + 1'b1;
			end else begin
				dcnt_q <= '0;
			end
			if (ctl.pop && q_head.kind == KIND_LOAD) begin
				tw_q <= q_head.rect_w;
				th_q <= q_head.rect_h;
			end
			if (ctl.start) begin
				have_match_q <= 1'b0;
				overflow_q   <= 1'b0;
				best_pos_q   <= '0;
				best_num_q   <= NUM_W'(threshold);
				best_den_q   <= UNI_W'(ONE_Q16);
			end
			if (ctl.skip) begin
				overflow_q <= 1'b1;
			end
			if (ctl.win) begin
				have_match_q <= 1'b1;
				best_pos_q   <= ent_q.index;
				best_num_q   <= NUM_W'(inter_q);
				best_den_q   <= uni_q;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			ent_q <= q_head;
		end
		if (st_q == B_AREA) begin
			inter_q <= AREA_W'(ent_q.inter_w) * AREA_W'(ent_q.inter_h);
			ta_q    <= AREA_W'(tw_q) * AREA_W'(th_q);
			ca_q    <= AREA_W'(ent_q.rect_w) * AREA_W'(ent_q.rect_h);
		end
		if (st_q == B_UNION) begin
			uni_q    <= uni_d;
			uni_sh_q <= PAD_W'(uni_d);
			den_sh_q <= PAD_W'(best_den_q);
			acc_l_q  <= '0;
			acc_r_q  <= '0;
		end
		if (st_q == B_MUL) begin
			acc_l_q  <= (acc_l_q << DIG_W) + PROD_W'(part_l);
			acc_r_q  <= (acc_r_q << DIG_W) + PROD_W'(part_r);
			den_sh_q <= den_sh_q << DIG_W;
			uni_sh_q <= uni_sh_q << DIG_W;
		end
		if (ctl.emit) begin
			found             <= have_match_q;
			best_index        <= have_match_q ? IDX_W'(best_pos_q) : '0;
			best_intersection <= have_match_q ? AREA_W'(best_num_q) : '0;
			best_union        <= have_match_q ? best_den_q : '0;
			overflowed        <= overflow_q;
		end
	end

endmodule

// File: src/rect_iou_best_match_unit.sv
// Top level of the rectangle IoU best-match unit: threshold register, front end,
// beat queue and scoring back end. Uses rim_pkg, rim_front, rim_queue, rim_back.
//
//   channel | handshake           | beat contents
//   input   | in_valid / in_stall | op, rect_x, rect_y, rect_w, rect_h, last
//   output  | out_valid/out_stall | found, best_index, best_intersection,
//           |                     | best_union, overflowed
//   config  | cfg_wr_en           | cfg_wr_data (match threshold, Q1.16)
//
// The front end takes one beat per cycle into a two-entry queue until it fills.
// The back end finishes a beat before popping the next: a load or over-capacity
// beat is handled in idle, a candidate in the area, union, multiply and compare
// states, cross-multiplying against the running best in serial 16-bit digits.
// Reset clears all control state; the test rectangle reads as zero until loaded.
// A stalled result holds the back end while the queue keeps filling.
module rect_iou_best_match_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rim_pkg::THR_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_x,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_y,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_w,
	input  logic [rim_pkg::COORD_BITS-1:0] rect_h,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [rim_pkg::IDX_W-1:0]      best_index,
	output logic [rim_pkg::AREA_W-1:0]     best_intersection,
	output logic [rim_pkg::UNI_W-1:0]      best_union,
	output logic                           overflowed
);
	import rim_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             q_push, q_pop, q_full, q_empty;
	rim_entry_t       q_entry, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(THR_RESET);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	rim_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.rect_x   (rect_x),
		.rect_y   (rect_y),
		.rect_w   (rect_w),
		.rect_h   (rect_h),
		.last     (last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	rim_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	rim_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.threshold         (thr_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.best_index        (best_index),
		.best_intersection (best_intersection),
		.best_union        (best_union),
		.overflowed        (overflowed)
	);

endmodule

// File: verif/rect_iou_best_match_unit_tb.sv
// Self-checking testbench for rect_iou_best_match_unit: directed and random rectangle
// searches, threshold changes between phases, predicted best matches checked per result beat.
// Depends on rim_pkg and rect_iou_best_match_unit from src.
module rect_iou_best_match_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rim_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASE_BEATS   = 24;
	localparam int LONG_LIST     = MAX_CANDIDATES + 6;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} rect_t;

	typedef struct packed {
		logic  op;
		rect_t r;
		logic  last;
	} rect_beat_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  index;
		logic [AREA_W-1:0] inter;
		logic [UNI_W-1:0]  uni;
		logic              ovf;
	} match_result_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [THR_W-1:0]      cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  op          = OP_LOAD;
	logic [COORD_BITS-1:0] rect_x      = '0;
	logic [COORD_BITS-1:0] rect_y      = '0;
	logic [COORD_BITS-1:0] rect_w      = '0;
	logic [COORD_BITS-1:0] rect_h      = '0;
	logic                  last        = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  found;
	logic [IDX_W-1:0]      best_index;
	logic [AREA_W-1:0]     best_intersection;
	logic [UNI_W-1:0]      best_union;
	logic                  overflowed;

	rect_iou_best_match_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.op                (op),
		.rect_x            (rect_x),
		.rect_y            (rect_y),
		.rect_w            (rect_w),
		.rect_h            (rect_h),
		.last              (last),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.best_index        (best_index),
		.best_intersection (best_intersection),
		.best_union        (best_union),
		.overflowed        (overflowed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted state of the search.
	logic [THR_W-1:0] thr_model;
	rect_t            test_rect;
	int unsigned      cand_count;
	logic [IDX_W-1:0] best_pos;
	logic             have_best;
	logic [UNI_W-1:0] best_num;
	logic [UNI_W:0]   best_den;
	logic             ovf_seen;

	rect_beat_t    beats_to_send[$];
	match_result_t predicted_matches[$];
	rect_beat_t    cur_beat;
	rect_t         gen_rect;
	int            beats_queued = 0;
	int            beats_taken  = 0;
	int            results_seen = 0;
	int            fail_count   = 0;
	int            cycle_count  = 0;
	int            tx_wait      = 0;
	int            rx_wait      = 0;
	int            rx_hold      = 0;
	bit            tx_burst     = 1'b0;
	bit            rx_burst     = 1'b0;
	bit            hold_request = 1'b0;

	function automatic rect_t box(input int x, input int y, input int w, input int h);
		rect_t r;
		r.x = COORD_BITS'(x);
		r.y = COORD_BITS'(y);
		r.w = COORD_BITS'(w);
		r.h = COORD_BITS'(h);
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] overlap_len(input logic [COORD_BITS-1:0] p1,
			input logic [COORD_BITS-1:0] s1, input logic [COORD_BITS-1:0] p2,
			input logic [COORD_BITS-1:0] s2);
		logic [COORD_BITS:0] e1, e2, lo, hi;
		e1 = {1'b0, p1} + {1'b0, s1};
		e2 = {1'b0, p2} + {1'b0, s2};
		lo = (p1 > p2) ? {1'b0, p1} : {1'b0, p2};
		hi = (e1 < e2) ? e1 : e2;
		return (hi > lo) ? COORD_BITS'(hi - lo) : '0;
	endfunction

	task automatic restart_search();
		cand_count = 0;
		best_pos   = '0;
		have_best  = 1'b0;
		best_num   = UNI_W'(thr_model);
		best_den   = (UNI_W+1)'(ONE_Q16);
		ovf_seen   = 1'b0;
	endtask

	task automatic score_beat(input rect_beat_t b);
		logic [COORD_BITS-1:0] iw, ih;
		logic [AREA_W-1:0]     inter;
		logic [UNI_W-1:0]      uni;
		match_result_t         res;
		if (b.op == OP_LOAD) begin
			test_rect = b.r;
			restart_search();
		end else if (cand_count >= MAX_CANDIDATES) begin
			ovf_seen = 1'b1;
		end else begin
			iw = overlap_len(test_rect.x, test_rect.w, b.r.x, b.r.w);
			ih = overlap_len(test_rect.y, test_rect.h, b.r.y, b.r.h);
			inter = AREA_W'(iw) * AREA_W'(ih);
			uni = UNI_W'(test_rect.w) * UNI_W'(test_rect.h)
				+ UNI_W'(b.r.w) * UNI_W'(b.r.h) - UNI_W'(inter);
			if (uni != 0 && 128'(inter) * 128'(best_den) > 128'(best_num) * 128'(uni)) begin
				best_num  = UNI_W'(inter);
				best_den  = (UNI_W+1)'(uni);
				best_pos  = cand_count[IDX_W-1:0];
				have_best = 1'b1;
			end
			cand_count++;
		end
		if (b.last) begin
			res.found = have_best;
			res.index = have_best ? best_pos : '0;
			res.inter = have_best ? best_num[AREA_W-1:0] : '0;
			res.uni   = have_best ? best_den[UNI_W-1:0] : '0;
			res.ovf   = ovf_seen;
			predicted_matches.push_back(res);
			restart_search();
		end
	endtask

	// Input side: one beat offered at a time, random gap after each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait = 0;
		end else begin
			if (in_valid && !in_stall) begin
				score_beat(cur_beat);
				beats_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_wait != 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					cur_beat = beats_to_send.pop_front();
					op       <= cur_beat.op;
					rect_x   <= cur_beat.r.x;
					rect_y   <= cur_beat.r.y;
					rect_w   <= cur_beat.r.w;
					rect_h   <= cur_beat.r.h;
					last     <= cur_beat.last;
					in_valid <= 1'b1;
					if ($urandom_range(0, 49) == 0)
						tx_burst = !tx_burst;
					tx_wait = tx_burst ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: checks every accepted result beat and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			rx_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (predicted_matches.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d arrived with nothing predicted", results_seen);
				end else begin
					match_result_t want;
					want = predicted_matches.pop_front();
					if (found !== want.found || best_index !== want.index ||
							best_intersection !== want.inter || best_union !== want.uni ||
							overflowed !== want.ovf) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d: expected found=%0b index=%0d inter=%0d %s",
								results_seen, want.found, want.index, want.inter,
								$sformatf("union=%0d ovf=%0b", want.uni, want.ovf));
							$display("result %0d: got found=%0b index=%0d inter=%0d %s",
								results_seen, found, best_index, best_intersection,
								$sformatf("union=%0d ovf=%0b", best_union, overflowed));
						end
					end
				end
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				rx_hold = LONG_HOLD;
			end else if (rx_hold != 0) begin
				rx_hold--;
			end
			out_stall <= (rx_wait != 0) || (rx_hold != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_beat(input logic op_i, input rect_t r, input logic last_i);
		rect_beat_t b;
		b.op   = op_i;
		b.r    = r;
		b.last = last_i;
		beats_to_send.push_back(b);
		beats_queued++;
	endtask

	task automatic wait_idle();
		while (beats_taken != beats_queued || predicted_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_model = value;
	endtask

	function automatic logic [COORD_BITS-1:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(COORD_BITS-1){1'b0}}};
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic rect_t pick_rect(input rect_t around, input bit near_ok);
		rect_t r;
		case ($urandom_range(0, near_ok ? 9 : 6))
			0: begin
				r.x = COORD_BITS'($urandom);
				r.y = COORD_BITS'($urandom);
				r.w = COORD_BITS'($urandom);
				r.h = COORD_BITS'($urandom);
			end
			1: begin
				r.x = extreme_coord();
				r.y = extreme_coord();
				r.w = extreme_coord();
				r.h = extreme_coord();
			end
			2, 3, 4, 5, 6: begin
				r = box($urandom_range(0, 40), $urandom_range(0, 40),
					$urandom_range(0, 30), $urandom_range(0, 30));
			end
			default: begin
				r.x = around.x + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
				r.y = around.y + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
				r.w = around.w + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
				r.h = around.h + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
			end
		endcase
		return r;
	endfunction

	// Mostly complete searches; some empty lists, lists continued without a load,
	// and searches dropped before their last beat.
	task automatic queue_random_search();
		int kind, n;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			gen_rect = pick_rect(gen_rect, 1'b0);
			send_beat(OP_LOAD, gen_rect, 1'b1);
		end else begin
			if (kind != 1) begin
				gen_rect = pick_rect(gen_rect, 1'b0);
				send_beat(OP_LOAD, gen_rect, 1'b0);
			end
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				send_beat(OP_CAND, pick_rect(gen_rect, 1'b1), (kind == 2) ? 1'b0 : (i == n - 1));
		end
	endtask

	initial begin
		logic [THR_W-1:0] thr;
		int               phase_end;
		rect_t            r;
		thr_model = THR_W'(THR_RESET);
		test_rect = '0;
		gen_rect  = '0;
		restart_search();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Candidates before any load score against an empty test rectangle.
		send_beat(OP_CAND, box(0, 0, 0, 0), 1'b0);
		send_beat(OP_CAND, box(0, 0, 65535, 65535), 1'b1);
		send_beat(OP_LOAD, box(10, 10, 20, 20), 1'b0);
		send_beat(OP_CAND, box(10, 10, 20, 20), 1'b0);
		send_beat(OP_CAND, box(15, 15, 20, 20), 1'b1);
		send_beat(OP_CAND, box(10, 10, 20, 20), 1'b1);
		send_beat(OP_LOAD, box(0, 0, 65535, 65535), 1'b1);
		send_beat(OP_LOAD, box(65535, 65535, 65535, 65535), 1'b0);
		send_beat(OP_CAND, box(65535, 65535, 65535, 65535), 1'b0);
		send_beat(OP_CAND, box(0, 0, 65535, 65535), 1'b1);
		// A ratio equal to the threshold does not count as a match.
		send_beat(OP_LOAD, box(0, 0, 4, 4), 1'b0);
		send_beat(OP_CAND, box(0, 0, 4, 2), 1'b0);
		send_beat(OP_CAND, box(0, 0, 0, 0), 1'b0);
		send_beat(OP_CAND, box(2, 0, 4, 4), 1'b1);
		send_beat(OP_LOAD, box(0, 0, 4, 4), 1'b0);
		wait_idle();

		// The open search keeps its old threshold.
		write_threshold(THR_W'(0));
		send_beat(OP_CAND, box(0, 0, 4, 2), 1'b1);
		send_beat(OP_LOAD, box(0, 0, 4, 4), 1'b0);
		send_beat(OP_CAND, box(100, 100, 4, 4), 1'b0);
		send_beat(OP_CAND, box(4, 0, 4, 4), 1'b0);
		send_beat(OP_CAND, box(3, 3, 4, 4), 1'b1);
		wait_idle();
		write_threshold(THR_W'(ONE_Q16));
		send_beat(OP_LOAD, box(0, 0, 4, 4), 1'b0);
		send_beat(OP_CAND, box(0, 0, 4, 4), 1'b1);
		wait_idle();
		write_threshold(THR_W'(ONE_Q16 - 1));
		send_beat(OP_LOAD, box(0, 0, 4, 4), 1'b0);
		send_beat(OP_CAND, box(0, 0, 4, 4), 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: thr = THR_W'(1);
				1: thr = THR_W'(ONE_Q16 - 1);
				3: thr = THR_W'(0);
				4: thr = THR_W'(ONE_Q16);
				default: thr = THR_W'($urandom_range(0, ONE_Q16));
			endcase
			write_threshold(thr);
			if (ph == 2)
				hold_request = 1'b1;
			phase_end = beats_queued + PHASE_BEATS;
			while (beats_queued < phase_end)
				queue_random_search();
		end

		// One list longer than the capacity; the best sits at the last scored position.
		wait_idle();
		write_threshold(THR_W'(49152));
		gen_rect = box(200, 300, 24, 16);
		send_beat(OP_LOAD, gen_rect, 1'b0);
		for (int i = 0; i < LONG_LIST; i++) begin
			if (i == MAX_CANDIDATES - 1 || i == MAX_CANDIDATES + 1) begin
				r = gen_rect;
			end else begin
				r = pick_rect(gen_rect, 1'b1);
				if (r == gen_rect)
					r.w = r.w + 1'b1;
			end
			send_beat(OP_CAND, r, i == LONG_LIST - 1);
		end
		queue_random_search();
		send_beat(OP_CAND, pick_rect(gen_rect, 1'b1), 1'b1);

		wait_idle();
		fail_count += predicted_matches.size();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
src/rim_pkg.sv
src/rim_front.sv
src/rim_queue.sv
src/rim_back.sv
src/rect_iou_best_match_unit.sv
verif/rect_iou_best_match_unit_tb.sv
